FILE: sv/mrc_pkg.sv
// Package for the modem response classifier: payload structs, codes, keyword tables.
// No dependencies.
`default_nettype none
package mrc_pkg;
   localparam int LINE_BYTES = 256;
   localparam int LEN_W = $clog2(LINE_BYTES);
   localparam int KW_COUNT = 9;
   localparam int POS_W = 4;
   localparam logic [POS_W-1:0] POS_MAX = 4'd15;

   localparam logic [2:0] RES_PENDING = 3'd0;
   localparam logic [2:0] RES_OK = 3'd1;
   localparam logic [2:0] RES_ERROR = 3'd2;
   localparam logic [2:0] RES_CONNECT = 3'd3;
   localparam logic [2:0] RES_OVERFLOW = 3'd4;

   // Line and batch classes share the low bits of the result codes.
   localparam logic [1:0] CLS_PENDING = 2'd0;
   localparam logic [1:0] CLS_OK = 2'd1;
   localparam logic [1:0] CLS_ERROR = 2'd2;
   localparam logic [1:0] CLS_CONNECT = 2'd3;

   localparam logic [1:0] POL_STANDARD = 2'd0;
   localparam logic [1:0] POL_CALL_END = 2'd2;
   localparam logic [1:0] POL_DATA = 2'd3;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       batch_last;
   } req_type;

   typedef struct packed {
      logic [2:0] result_code;
      logic [1:0] provisional_code;
   } rsp_type;

   // Event handed from the front (line parser) to the back (batch merger).
   typedef struct packed {
      logic       line_end;   // a line closed, line_class valid
      logic [1:0] line_class; // pending/ok/error/connect
      logic       overflow;
      logic       last;
   } evt_type;

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd2, 4'd5, 4'd10, 4'd10, 4'd7,
                                               4'd10, 4'd4, 4'd9, 4'd11};
   localparam logic [KW_COUNT-1:0] KW_PREFIX = 9'b000011100;

   function automatic logic [7:0] kw_char(input int k, input logic [3:0] p);
      logic [8*11-1:0] s;
      unique case (k)
         0: s = {"OK", 72'h0};
         1: s = {"ERROR", 48'h0};
         2: s = {"+CME ERROR", 8'h0};
         3: s = {"+CMS ERROR", 8'h0};
         4: s = {"CONNECT", 32'h0};
         5: s = {"NO CARRIER", 8'h0};
         6: s = {"BUSY", 56'h0};
         7: s = {"NO ANSWER", 16'h0};
         default: s = "NO DIALTONE";
      endcase
      if (p > 4'd10) kw_char = 8'h00;
      else kw_char = s[8*(10-int'(p)) +: 8];
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      is_blank = (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
   endfunction
endpackage
`default_nettype wire

FILE: sv/mrc_front.sv
// Front end: line parser with streaming keyword matchers; emits line, overflow and batch-end events.
// Depends on mrc_pkg.
`default_nettype none
module mrc_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear,
   input  wire logic [1:0]       policy,
   input  wire logic             take,
   input  wire mrc_pkg::req_type req,
   output mrc_pkg::evt_type      evt,
   output logic                  evt_valid
);
   logic [mrc_pkg::LEN_W-1:0]    len_ff, len_in;
   logic                         seen_ff, seen_in;
   logic [mrc_pkg::POS_W-1:0]    pos_ff, pos_in;
   logic [mrc_pkg::KW_COUNT-1:0] alive_ff, alive_in, done_ff, done_in;
   logic                         drop_ff, drop_in;
   logic [7:0]                   c, u;
   logic                         term, ovf;
   logic [1:0]                   cls;

   always_comb begin
      c = req.rx_byte;
      u = (c >= 8'h61 && c <= 8'h7A) ? c - 8'd32 : c;
      term = (c == 8'h0D) || (c == 8'h0A);
      ovf = !term && ({1'b0, len_ff} + 9'd1 >= 9'(mrc_pkg::LINE_BYTES));
      cls = mrc_pkg::CLS_PENDING;
      if (seen_ff) begin
         priority if (done_ff[0]) cls = mrc_pkg::CLS_OK;
         else if (|done_ff[3:1]) cls = mrc_pkg::CLS_ERROR;
         else if (done_ff[4])
            cls = (policy == mrc_pkg::POL_DATA) ? mrc_pkg::CLS_CONNECT : mrc_pkg::CLS_PENDING;
         else if (|done_ff[8:5]) begin
            if (policy == mrc_pkg::POL_STANDARD) cls = mrc_pkg::CLS_PENDING;
            else if (policy == mrc_pkg::POL_CALL_END) cls = mrc_pkg::CLS_OK;
            else cls = mrc_pkg::CLS_ERROR;
         end
         else cls = mrc_pkg::CLS_PENDING;
      end
      len_in = len_ff; seen_in = seen_ff; pos_in = pos_ff;
      alive_in = alive_ff; done_in = done_ff; drop_in = drop_ff;
      evt = '0; evt_valid = 1'b0;
      evt.last = req.batch_last;
      if (take) begin
         if (drop_ff) begin
            if (req.batch_last) drop_in = 1'b0;
         end else if (term) begin
            evt_valid = 1'b1; evt.line_end = 1'b1; evt.line_class = cls;
            len_in = '0; seen_in = 1'b0; pos_in = '0; alive_in = '1; done_in = '0;
         end else if (ovf) begin
            evt_valid = 1'b1; evt.overflow = 1'b1;
            drop_in = !req.batch_last;
         end else begin
            evt_valid = req.batch_last;
            len_in = len_ff + 1'b1;
            if (seen_ff || !mrc_pkg::is_blank(c)) begin
               seen_in = 1'b1;
               for (int k = 0; k < mrc_pkg::KW_COUNT; k++) begin
                  if (pos_ff < mrc_pkg::KW_LEN[k]) begin
                     if (alive_ff[k] && u == mrc_pkg::kw_char(k, pos_ff)) begin
                        if (pos_ff + 4'd1 == mrc_pkg::KW_LEN[k]) begin
                           done_in[k] = 1'b1; alive_in[k] = 1'b0;
                        end
                     end else alive_in[k] = 1'b0;
                  end else if (done_ff[k]) begin
                     if (mrc_pkg::KW_PREFIX[k] && pos_ff == mrc_pkg::KW_LEN[k]) begin
                        if (c == 8'h20 || c == 8'h3A) alive_in[k] = 1'b1;
                        else if (!mrc_pkg::is_blank(c)) done_in[k] = 1'b0;
                     end else if (!alive_ff[k] && !mrc_pkg::is_blank(c)) done_in[k] = 1'b0;
                  end
               end
               pos_in = (pos_ff < mrc_pkg::POS_MAX) ? pos_ff + 4'd1 : mrc_pkg::POS_MAX;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         len_ff <= '0; seen_ff <= 1'b0; pos_ff <= '0;
         alive_ff <= '1; done_ff <= '0; drop_ff <= 1'b0;
      end else begin
         len_ff <= len_in; seen_ff <= seen_in; pos_ff <= pos_in;
         alive_ff <= alive_in; done_ff <= done_in; drop_ff <= drop_in;
      end
   end
endmodule
`default_nettype wire

FILE: sv/mrc_queue.sv
// Two-entry event queue between front and back.
// Depends on mrc_pkg.
`default_nettype none
module mrc_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear,
   input  wire logic             push,
   input  wire mrc_pkg::evt_type push_data,
   input  wire logic             pop,
   output logic                  not_empty,
   output logic                  full,
   output mrc_pkg::evt_type      head
);
   mrc_pkg::evt_type mem_ff [2];
   logic rd_ff, wr_ff;
   logic [1:0] cnt_ff;

   assign not_empty = cnt_ff != 2'd0;
   assign full = cnt_ff == 2'd2;
   assign head = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
      if (reset || clear) begin
         rd_ff <= 1'b0; wr_ff <= 1'b0; cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= !wr_ff;
         if (pop) rd_ff <= !rd_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule
`default_nettype wire

FILE: sv/mrc_back.sv
// Back end: merges line results per batch, applies policy, registers the result beat.
// Depends on mrc_pkg.
`default_nettype none
module mrc_back (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             clear,
   input  wire logic [1:0]       policy,
   input  wire logic             evt_valid,
   input  wire mrc_pkg::evt_type evt,
   output logic                  evt_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mrc_pkg::rsp_type      rsp_data
);
   logic [1:0] agg_ff, agg_in, held_ff, held_in, res;
   logic       vld_ff, emit, slot;
   mrc_pkg::rsp_type out_ff, out_in;

   assign slot = !vld_ff || !rsp_stall;
   assign evt_pop = evt_valid && slot;
   assign rsp_valid = vld_ff;
   assign rsp_data = out_ff;

   always_comb begin
      agg_in = agg_ff; held_in = held_ff; emit = 1'b0; out_in = out_ff;
      res = mrc_pkg::CLS_PENDING;
      if (evt_pop) begin
         if (evt.overflow) begin
            agg_in = mrc_pkg::CLS_PENDING; emit = 1'b1;
            out_in.result_code = mrc_pkg::RES_OVERFLOW;
            out_in.provisional_code = held_ff;
         end else begin
            if (evt.line_end) begin
               if (evt.line_class == mrc_pkg::CLS_ERROR) agg_in = mrc_pkg::CLS_ERROR;
               else if (agg_ff != mrc_pkg::CLS_ERROR && evt.line_class == mrc_pkg::CLS_CONNECT)
                  agg_in = mrc_pkg::CLS_CONNECT;
               else if (agg_ff == mrc_pkg::CLS_PENDING && evt.line_class == mrc_pkg::CLS_OK)
                  agg_in = mrc_pkg::CLS_OK;
            end
            if (evt.last) begin
               res = agg_in;
               if (policy != mrc_pkg::POL_STANDARD &&
                   (res == mrc_pkg::CLS_OK || res == mrc_pkg::CLS_CONNECT)) begin
                  held_in = res; res = mrc_pkg::CLS_PENDING;
               end
               agg_in = mrc_pkg::CLS_PENDING; emit = 1'b1;
               out_in.result_code = {1'b0, res};
               out_in.provisional_code = held_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      if (reset || clear) begin
         agg_ff <= '0; held_ff <= '0; vld_ff <= 1'b0;
      end else begin
         agg_ff <= agg_in; held_ff <= held_in;
         if (slot) vld_ff <= emit;
      end
   end
endmodule
`default_nettype wire

FILE: sv/modem_response_classifier.sv
// Modem response classifier. A result beat follows the byte that causes it through
// the front parse, the event queue and the registered output.
// Throughput: one byte per cycle when the queue is not full (combinational matchers).
// Reset (synchronous, active high) and any csr write clear all parser and batch state;
// the csr write also loads the command policy. No clearing pass is needed.
`default_nettype none
module modem_response_classifier (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire mrc_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output mrc_pkg::rsp_type      rsp_data,
   input  wire logic             csr_write,
   input  wire logic [1:0]       csr_data
);
   logic [1:0] policy_ff;
   logic take, push, full, ne, pop;
   mrc_pkg::evt_type fev, hev;

   // Hold new bytes while the queue is full.
   assign req_stall = full;
   assign take = req_valid && !full;

   always_ff @(posedge clock) begin
      if (reset) policy_ff <= mrc_pkg::POL_STANDARD;
      else if (csr_write) policy_ff <= csr_data;
   end

   mrc_front u_front (.clock, .reset, .clear(csr_write), .policy(policy_ff), .take,
                      .req(req_data), .evt(fev), .evt_valid(push));
   mrc_queue u_queue (.clock, .reset, .clear(csr_write), .push, .push_data(fev), .pop,
                      .not_empty(ne), .full, .head(hev));
   mrc_back u_back (.clock, .reset, .clear(csr_write), .policy(policy_ff),
                    .evt_valid(ne), .evt(hev), .evt_pop(pop), .rsp_valid, .rsp_stall,
                    .rsp_data);
endmodule
`default_nettype wire
